// ----- rtl/zef_pkg.sv -----
// shared types and constants for the zero-escaped frame encoder
// no dependencies

package zef_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] FLAG_BASE  = 8'd128;
  localparam logic [7:0] CHECK_MOD  = 8'd255;
  localparam logic [7:0] START_BYTE = 8'h00;

  localparam logic [2:0] POS_START = 3'd0;
  localparam logic [2:0] POS_CMD   = 3'd1;
  localparam logic [2:0] POS_YHI   = 3'd2;
  localparam logic [2:0] POS_YLO   = 3'd3;
  localparam logic [2:0] POS_XHI   = 3'd4;
  localparam logic [2:0] POS_XLO   = 3'd5;
  localparam logic [2:0] POS_FLAG  = 3'd6;
  localparam logic [2:0] POS_CHECK = 3'd7;

  typedef struct packed {
    logic [7:0] command;
    logic [7:0] yhi;
    logic [7:0] ylo;
    logic [7:0] xhi;
    logic [7:0] xlo;
    logic [7:0] flag;
    logic [7:0] chk;
  } frame_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ----- rtl/zef_front.sv -----
// front end: escapes zero data bytes, builds flag and mod-255 checksum
// depends on zef_pkg

module zef_front import zef_pkg::*; (
  input  logic        start,
  input  logic        busy,
  input  logic [7:0]  command,
  input  logic [15:0] y_value,
  input  logic [15:0] x_value,
  output logic        push,
  output frame_t      entry
);

  logic [10:0] sum;
  logic [8:0]  fold;
  logic [8:0]  fold_sub;
  logic [7:0]  chk;

  always_comb begin
    entry.command = command;
    entry.flag    = FLAG_BASE;
    entry.ylo     = (y_value[7:0]  == 8'd0) ? 8'd1 : y_value[7:0];
    entry.yhi     = (y_value[15:8] == 8'd0) ? 8'd1 : y_value[15:8];
    entry.xlo     = (x_value[7:0]  == 8'd0) ? 8'd1 : x_value[7:0];
    entry.xhi     = (x_value[15:8] == 8'd0) ? 8'd1 : x_value[15:8];
    entry.flag[0] = (y_value[7:0]  == 8'd0);
    entry.flag[1] = (y_value[15:8] == 8'd0);
    entry.flag[2] = (x_value[7:0]  == 8'd0);
    entry.flag[3] = (x_value[15:8] == 8'd0);
    sum = {3'd0, command} + {3'd0, entry.yhi} + {3'd0, entry.ylo}
        + {3'd0, entry.xhi} + {3'd0, entry.xlo} + {3'd0, entry.flag};
    // 256 == 1 mod 255, so fold the high bits onto the low byte
    fold     = {6'd0, sum[10:8]} + {1'b0, sum[7:0]};
    fold_sub = fold - {1'b0, CHECK_MOD};
    chk      = (fold >= {1'b0, CHECK_MOD}) ? fold_sub[7:0] : fold[7:0];
    entry.chk = chk;
    push = start && !busy && (chk != 8'd0);
  end

endmodule

// ----- rtl/zef_queue.sv -----
// short frame queue between front end and serializer
// depends on zef_pkg

module zef_queue import zef_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  frame_t    push_entry,
  input  logic      pop,
  output frame_t    head,
  output q_status_t status
);

  frame_t           mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    ptr_inc = (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status.empty = (count == '0);
  assign status.full  = (count == QCntW'(QDepth));
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) status.full |-> !push)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) status.empty |-> !pop)
    else $error("pop from empty queue");

endmodule

// ----- rtl/zef_back.sv -----
// back end: serializes one queued frame, one byte per cycle
// depends on zef_pkg

module zef_back import zef_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  frame_t     head,
  input  q_status_t  status,
  output logic       pop,
  output logic [7:0] frame_byte,
  output logic       last_byte,
  output logic       strobe
);

  logic [2:0] pos;
  logic [7:0] byte_sel;

  always_comb begin
    case (pos)
      POS_START: byte_sel = START_BYTE;
      POS_CMD:   byte_sel = head.command;
      POS_YHI:   byte_sel = head.yhi;
      POS_YLO:   byte_sel = head.ylo;
      POS_XHI:   byte_sel = head.xhi;
      POS_XLO:   byte_sel = head.xlo;
      POS_FLAG:  byte_sel = head.flag;
      POS_CHECK: byte_sel = head.chk;
      default:   byte_sel = START_BYTE;
    endcase
  end

  assign pop = !status.empty && (pos == POS_CHECK);

  always_ff @(posedge clk) begin
    if (!status.empty) begin
      frame_byte <= byte_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_START;
      strobe    <= 1'b0;
      last_byte <= 1'b0;
    end else begin
      strobe    <= !status.empty;
      last_byte <= pop;
      if (!status.empty) pos <= pos + 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) last_byte |-> strobe)
    else $error("last byte without strobe");
  assert property (@(posedge clk) disable iff (rst) (strobe && !last_byte) |=> strobe)
    else $error("gap inside frame");
  assert property (@(posedge clk) disable iff (rst)
      (strobe && last_byte) |=> (!strobe || (frame_byte == START_BYTE)))
    else $error("frame does not open with start byte");
  assert property (@(posedge clk) disable iff (rst) status.empty |-> (pos == POS_START))
    else $error("serializer idle mid-frame");

endmodule

// ----- rtl/zero_escaped_frame_encoder.sv -----
// top level of the zero-escaped frame encoder
// depends on zef_pkg, zef_front, zef_queue, zef_back
//
// usage:
//   a transaction is taken on a rising edge with start high and busy low;
//   command, y_value and x_value are sampled at that edge
//   the front end escapes zero data bytes, builds the flag byte and the
//   mod-255 checksum in the same cycle and writes the frame into a
//   two-entry queue; a frame whose checksum is zero is dropped
//   the serializer sends 8 bytes on consecutive cycles: 0, command,
//   y high, y low, x high, x low, flag, checksum, each valid for one
//   cycle with strobe high; last_byte marks the checksum byte
//   the frame is written into the queue at the accepting edge; its bytes
//   go out one per cycle once it reaches the queue head, and new frames
//   are taken meanwhile; busy is high while both queue entries are held
//   the receiver cannot stall; strobed bytes must be taken as they come
//   reset (rst, synchronous) empties the queue and drops any frame in flight

module zero_escaped_frame_encoder import zef_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  command,
  input  logic [15:0] y_value,
  input  logic [15:0] x_value,
  output logic [7:0]  frame_byte,
  output logic        last_byte,
  output logic        strobe
);

  logic      push;
  logic      pop;
  frame_t    entry;
  frame_t    head;
  q_status_t status;

  assign busy = status.full;

  zef_front u_front (
    .start   (start),
    .busy    (busy),
    .command (command),
    .y_value (y_value),
    .x_value (x_value),
    .push    (push),
    .entry   (entry)
  );

  zef_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  zef_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .status     (status),
    .pop        (pop),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .strobe     (strobe)
  );

endmodule

// ----- verif/zero_escaped_frame_encoder_test.sv -----
// self-checking testbench for zero_escaped_frame_encoder: directed table, then random frames
// depends on zef_pkg and the zero_escaped_frame_encoder rtl

module zero_escaped_frame_encoder_test import zef_pkg::*;;

  localparam int unsigned RandomItems = 110;
  localparam int unsigned StallLimit  = 200;
  localparam int unsigned TailCycles  = 24;
  localparam int unsigned FrameLen    = 8;
  localparam int unsigned ResetCycles = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_entry_t;

  typedef struct packed {
    logic [7:0]  cmd;
    logic [15:0] y;
    logic [15:0] x;
    logic        typed;
    logic [3:0]  len;
    logic [63:0] frame;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [7:0]  command = 8'd0;
  logic [15:0] y_value = 16'd0;
  logic [15:0] x_value = 16'd0;
  logic        busy;
  logic [7:0]  frame_byte;
  logic        last_byte;
  logic        strobe;

  // typed expectation that travels with the driven transaction
  logic        row_typed = 1'b0;
  logic [3:0]  row_len = 4'd0;
  logic [63:0] row_frame = 64'd0;

  frame_entry_t pending_bytes [$];
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles = 0;
  logic         burst_mode = 1'b0;

  stim_row_t directed_rows [21] = '{
    '{8'h00, 16'h0000, 16'h0000, 1'b1, 4'd8, 64'h00_00_01_01_01_01_8f_93},
    '{8'hff, 16'hffff, 16'hffff, 1'b1, 4'd8, 64'h00_ff_ff_ff_ff_ff_80_80},
    '{8'hff, 16'h0000, 16'h0000, 1'b1, 4'd8, 64'h00_ff_01_01_01_01_8f_93},
    '{8'h01, 16'hff00, 16'hffff, 1'b1, 4'd8, 64'h00_01_ff_01_ff_ff_81_83},
    '{8'h7b, 16'h0101, 16'h0101, 1'b1, 4'd0, 64'h0},
    '{8'h00, 16'h7c01, 16'h0101, 1'b1, 4'd0, 64'h0},
    '{8'hff, 16'h7c01, 16'h0101, 1'b1, 4'd0, 64'h0},
    '{8'h7a, 16'h0101, 16'h0101, 1'b1, 4'd8, 64'h00_7a_01_01_01_01_80_fe},
    '{8'h7c, 16'h0101, 16'h0101, 1'b1, 4'd8, 64'h00_7c_01_01_01_01_80_01},
    '{8'h00, 16'h1234, 16'h5678, 1'b0, 4'd0, 64'h0},
    '{8'ha5, 16'hab00, 16'h1111, 1'b0, 4'd0, 64'h0},
    '{8'h5a, 16'h00cd, 16'h2222, 1'b0, 4'd0, 64'h0},
    '{8'h3c, 16'h3333, 16'h1200, 1'b0, 4'd0, 64'h0},
    '{8'hc3, 16'h4444, 16'h0034, 1'b0, 4'd0, 64'h0},
    '{8'h80, 16'h0000, 16'hffff, 1'b0, 4'd0, 64'h0},
    '{8'h7f, 16'hffff, 16'h0000, 1'b0, 4'd0, 64'h0},
    '{8'h01, 16'h0001, 16'h0100, 1'b0, 4'd0, 64'h0},
    '{8'hfe, 16'h8000, 16'h0080, 1'b0, 4'd0, 64'h0},
    '{8'hff, 16'h0100, 16'h0001, 1'b0, 4'd0, 64'h0},
    '{8'h55, 16'haaaa, 16'h5555, 1'b0, 4'd0, 64'h0},
    '{8'haa, 16'h5555, 16'haaaa, 1'b0, 4'd0, 64'h0}
  };

  zero_escaped_frame_encoder dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .y_value    (y_value),
    .x_value    (x_value),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .strobe     (strobe)
  );

  always #1 clk = ~clk;

  task automatic push_encoded_frame(input logic [7:0] cmd, input logic [15:0] y,
                                    input logic [15:0] x);
    logic [7:0]  yhi, ylo, xhi, xlo, flag, chk;
    logic [10:0] total;
    logic [7:0]  bytes [8];
    flag = FLAG_BASE;
    ylo = y[7:0];
    yhi = y[15:8];
    xlo = x[7:0];
    xhi = x[15:8];
    if (ylo == 8'd0) begin
      ylo = 8'd1;
      flag[0] = 1'b1;
    end
    if (yhi == 8'd0) begin
      yhi = 8'd1;
      flag[1] = 1'b1;
    end
    if (xlo == 8'd0) begin
      xlo = 8'd1;
      flag[2] = 1'b1;
    end
    if (xhi == 8'd0) begin
      xhi = 8'd1;
      flag[3] = 1'b1;
    end
    total = 11'(cmd) + 11'(yhi) + 11'(ylo) + 11'(xhi) + 11'(xlo) + 11'(flag);
    chk = 8'(total % 11'(CHECK_MOD));
    if (chk == 8'd0) return;
    bytes = '{START_BYTE, cmd, yhi, ylo, xhi, xlo, flag, chk};
    for (int k = 0; k < FrameLen; k++) begin
      pending_bytes.push_back('{bytes[k], (k == FrameLen - 1)});
    end
  endtask

  // receiver side and watchdog
  always @(posedge clk) begin
    frame_entry_t want;
    logic moved;
    moved = 1'b0;
    if (!rst) begin
      if (strobe === 1'b1) begin
        moved = 1'b1;
        if (pending_bytes.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected byte: expected none, actual frame_byte %h last_byte %b",
                   $time, frame_byte, last_byte);
        end else begin
          want = pending_bytes.pop_front();
          if (frame_byte !== want.data) begin
            mismatch_count++;
            $display("%0t frame_byte mismatch: expected %h actual %h",
                     $time, want.data, frame_byte);
          end
          if (last_byte !== want.last) begin
            mismatch_count++;
            $display("%0t last_byte mismatch: expected %b actual %b",
                     $time, want.last, last_byte);
          end
        end
      end
      if (start && busy === 1'b0) begin
        moved = 1'b1;
        if (row_typed) begin
          for (int k = 0; k < row_len; k++) begin
            pending_bytes.push_back('{row_frame[63 - 8 * k -: 8], (k == row_len - 1)});
          end
        end else begin
          push_encoded_frame(command, y_value, x_value);
        end
      end
    end
    if (rst || moved) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, StallLimit);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned next_gap();
    return burst_mode ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [7:0] rand_byte();
    return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input logic [7:0] cmd, input logic [15:0] y, input logic [15:0] x,
                           input logic typed, input logic [3:0] len, input logic [63:0] frame,
                           input int unsigned gap);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    y_value <= y;
    x_value <= x;
    row_typed <= typed;
    row_len <= len;
    row_frame <= frame;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic wait_for_frames();
    @(negedge clk);
    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0]  cmd;
    logic [15:0] y, x;
    logic [31:0] vals;
    logic [7:0]  b;
    int unsigned partial;
    repeat (ResetCycles) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (i % 8 == 0) burst_mode = ($urandom_range(0, 1) == 0);
      send_item(directed_rows[i].cmd, directed_rows[i].y, directed_rows[i].x,
                directed_rows[i].typed, directed_rows[i].len, directed_rows[i].frame,
                next_gap());
    end
    wait_for_frames();

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 16 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      if (i == RandomItems / 2) wait_for_frames();
      y = {rand_byte(), rand_byte()};
      x = {rand_byte(), rand_byte()};
      cmd = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      // pick the command that makes the checksum zero
      if ($urandom_range(0, 5) == 0) begin
        vals = {x, y};
        partial = FLAG_BASE;
        for (int j = 0; j < 4; j++) begin
          b = vals[8 * j +: 8];
          partial += (b == 8'd0) ? (1 + (1 << j)) : b;
        end
        cmd = 8'((CHECK_MOD - partial % CHECK_MOD) % CHECK_MOD);
      end
      send_item(cmd, y, x, 1'b0, 4'd0, 64'd0, next_gap());
    end

    wait_for_frames();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- zero_escaped_frame_encoder.f -----
rtl/zef_pkg.sv
rtl/zef_front.sv
rtl/zef_queue.sv
rtl/zef_back.sv
rtl/zero_escaped_frame_encoder.sv
verif/zero_escaped_frame_encoder_test.sv
